// ===== rtl/core/random_ulp_perturber_macros.svh =====
// assertion macros for the random ulp perturber
`ifndef RANDOM_ULP_PERTURBER_MACROS_SVH
`define RANDOM_ULP_PERTURBER_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define RUP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rup assertion failed");

// next-cycle implication under synchronous active-low reset
`define RUP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rup assertion failed");

`endif

// ===== rtl/core/rup_pkg.sv =====
// types, constants and helper functions for the random ulp perturber
`timescale 1ns / 1ps

package rup_pkg;

  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned ROT_SUM = 17;
  localparam int unsigned ROT_A   = 49;
  localparam int unsigned SHIFT_B = 21;
  localparam int unsigned ROT_C   = 28;

  typedef struct packed {
    logic        is_double;
    logic [63:0] value_bits;
  } rup_in_t;

  typedef struct packed {
    logic [63:0] result_bits;
    logic        stepped_up;
    logic        passed_zero;
  } rup_out_t;

  typedef struct packed {
    logic        busy;
    logic        load;
    logic [63:0] word;
  } rup_seed_stat_t;

  typedef struct packed {
    logic [63:0] w0;
    logic [63:0] w1;
  } rup_gen_t;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned amt);
    rotl64 = (v << amt) | (v >> (64 - amt));
  endfunction

  // elaboration only, gives the reset state of the generator
  function automatic logic [63:0] splitmix64_const(input logic [63:0] v);
    logic [63:0] z;
    z = v + GOLDEN_GAMMA;
    z = (z ^ (z >> 30)) * MIX_MUL_A;
    z = (z ^ (z >> 27)) * MIX_MUL_B;
    splitmix64_const = z ^ (z >> 31);
  endfunction

  localparam logic [63:0] RESET_WORD = splitmix64_const(64'd0);

  // bit 0 of rotl(w0 + w1, 17) + w0
  function automatic logic draw_bit0(input rup_gen_t g);
    logic [63:0] s;
    s = g.w0 + g.w1;
    draw_bit0 = s[64 - ROT_SUM] ^ g.w0[0];
  endfunction

  function automatic rup_gen_t gen_step(input rup_gen_t g);
    logic [63:0] x;
    rup_gen_t    n;
    x    = g.w0 ^ g.w1;
    n.w0 = rotl64(g.w0, ROT_A) ^ x ^ (x << SHIFT_B);
    n.w1 = rotl64(x, ROT_C);
    gen_step = n;
  endfunction

endpackage

// ===== rtl/core/rup_seed.sv =====
// seed mixer: splitmix64 of the written seed through one shared 32x32 multiplier
`timescale 1ns / 1ps

module rup_seed (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [63:0]              cfg_wr_data,
  output rup_pkg::rup_seed_stat_t  seed_stat
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_A0, ST_A1, ST_A2, ST_B0, ST_B1, ST_B2
  } state_t;

  state_t      state_r;
  logic        load_r;
  logic [63:0] word_r;
  logic [63:0] op_r;
  logic [63:0] acc_r;

  logic [63:0] seed_sum;
  logic [31:0] mul_x;
  logic [31:0] mul_k;
  logic [63:0] prod;
  logic [63:0] acc_nxt;

  assign seed_sum = cfg_wr_data + rup_pkg::GOLDEN_GAMMA;

  always_comb begin
    mul_x = op_r[31:0];
    mul_k = rup_pkg::MIX_MUL_A[31:0];
    unique case (state_r)
      ST_A1: begin
        mul_x = op_r[63:32];
      end
      ST_A2: begin
        mul_k = rup_pkg::MIX_MUL_A[63:32];
      end
      ST_B0: begin
        mul_k = rup_pkg::MIX_MUL_B[31:0];
      end
      ST_B1: begin
        mul_x = op_r[63:32];
        mul_k = rup_pkg::MIX_MUL_B[31:0];
      end
      ST_B2: begin
        mul_k = rup_pkg::MIX_MUL_B[63:32];
      end
      default: begin
      end
    endcase
  end

  assign prod    = 64'(mul_x) * 64'(mul_k);
  assign acc_nxt = acc_r + {prod[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      load_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      op_r    <= seed_sum ^ (seed_sum >> 30);
      state_r <= ST_A0;
      load_r  <= 1'b0;
    end else begin
      load_r <= (state_r == ST_B2);
      unique case (state_r)
        ST_IDLE: begin
        end
        ST_A0, ST_B0: begin
          acc_r   <= prod;
          state_r <= (state_r == ST_A0) ? ST_A1 : ST_B1;
        end
        ST_A1, ST_B1: begin
          acc_r   <= acc_nxt;
          state_r <= (state_r == ST_A1) ? ST_A2 : ST_B2;
        end
        ST_A2: begin
          op_r    <= acc_nxt ^ (acc_nxt >> 27);
          state_r <= ST_B0;
        end
        ST_B2: begin
          word_r  <= acc_nxt ^ (acc_nxt >> 31);
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign seed_stat.busy = (state_r != ST_IDLE) | load_r;
  assign seed_stat.load = load_r;
  assign seed_stat.word = word_r;

endmodule

// ===== rtl/core/random_ulp_perturber.sv =====
// random ulp perturber: steps a float bit pattern up or down by one at random
//
// input channel in_valid / in_stall / in_word carries one word per float:
// the format flag and the raw bit pattern. output channel out_valid /
// out_stall / out_word carries the stepped pattern with up and zero flags.
// out_valid rises the cycle after a word is accepted; a word can be taken
// every cycle in_stall is low, and the xoroshiro128++ state steps with
// each word. plus and minus zero pass through unchanged and leave the
// generator alone. a stalled output word holds; a new word is still taken
// in the cycle the held one leaves, so in_stall rises only while the
// output is held or a reseed runs. writing cfg_wr_data with cfg_wr_en
// sets both generator words to splitmix64 of the seed; the mix runs
// through one shared 32x32 multiplier in six steps, with in_stall high
// until the load. reset clears out_valid and loads splitmix64 of zero.
`timescale 1ns / 1ps
`include "random_ulp_perturber_macros.svh"

module random_ulp_perturber (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rup_pkg::rup_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output rup_pkg::rup_out_t out_word,
  input  logic             cfg_wr_en,
  input  logic [63:0]      cfg_wr_data
);

  rup_pkg::rup_seed_stat_t seed_stat;
  rup_pkg::rup_gen_t       gen_r;
  rup_pkg::rup_gen_t       gen_nxt;
  rup_pkg::rup_out_t       out_word_r;
  rup_pkg::rup_out_t       out_word_nxt;
  logic                    out_valid_r;

  logic        in_fire;
  logic        in_zero;
  logic        step_up;
  logic [63:0] masked;
  logic [63:0] stepped;

  rup_seed u_seed (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .seed_stat   (seed_stat)
  );

  assign in_stall = seed_stat.busy | (out_valid_r & out_stall);
  assign in_fire  = in_valid & ~in_stall;

  assign masked  = in_word.is_double ? in_word.value_bits
                                     : {32'd0, in_word.value_bits[31:0]};
  assign in_zero = in_word.is_double ? (in_word.value_bits[62:0] == 63'd0)
                                     : (in_word.value_bits[30:0] == 31'd0);
  assign step_up = rup_pkg::draw_bit0(gen_r);
  assign stepped = masked + (step_up ? 64'd1 : {64{1'b1}});

  always_comb begin
    if (in_zero) begin
      out_word_nxt.result_bits = masked;
      out_word_nxt.stepped_up  = 1'b0;
      out_word_nxt.passed_zero = 1'b1;
    end else begin
      out_word_nxt.result_bits = in_word.is_double ? stepped : {32'd0, stepped[31:0]};
      out_word_nxt.stepped_up  = step_up;
      out_word_nxt.passed_zero = 1'b0;
    end
  end

  always_comb begin
    priority if (seed_stat.load) begin
      gen_nxt.w0 = seed_stat.word;
      gen_nxt.w1 = seed_stat.word;
    end else if (in_fire && !in_zero) begin
      gen_nxt = rup_pkg::gen_step(gen_r);
    end else begin
      gen_nxt = gen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r.w0    <= rup_pkg::RESET_WORD;
      gen_r.w1    <= rup_pkg::RESET_WORD;
      out_valid_r <= 1'b0;
    end else begin
      gen_r <= gen_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `RUP_ASSERT_NEXT(a_cfg_stalls, clk, rst_n, cfg_wr_en, in_stall)
  `RUP_ASSERT_NOW(a_seed_no_fire, clk, rst_n, seed_stat.busy, !in_fire)
  `RUP_ASSERT_NEXT(a_zero_keeps_gen, clk, rst_n, in_fire && in_zero && !cfg_wr_en, $stable(gen_r))
  `RUP_ASSERT_NOW(a_flags_excl, clk, rst_n, out_valid_r, !(out_word_r.stepped_up && out_word_r.passed_zero))

endmodule
